// ===== hw/rtl/scf_pkg.sv =====
// scf_pkg: shared types, kind codes and helpers for the screen filter color fader.
// No dependencies.
`default_nettype none
package scf_pkg;
    localparam int TimeBits = 16;
    localparam int ChBits = 8;
    localparam int FracBits = 17;
    localparam int DivBits = TimeBits + 17;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_SET     = 2'd1,
        OP_DISABLE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    localparam logic [3:0] K_PASS  = 4'd0;
    localparam logic [3:0] K_MUL   = 4'd1;
    localparam logic [3:0] K_ADD   = 4'd3;
    localparam logic [3:0] K_BLEND = 4'd5;
    localparam logic [3:0] K_WIDE  = 4'd6;
    localparam logic [3:0] K_NOCOL = 4'd8;

    typedef struct packed {
        op_t                 op;
        logic [TimeBits-1:0] elapsed;
        logic [3:0]          kind;
        logic [3:0]          shape;
        logic [TimeBits-1:0] fade_time;
        logic [4*ChBits-1:0] color;
        logic [31:0]         texture_id;
        logic                texture_given;
    } cmd_t;

    typedef struct packed {
        logic [3:0]          kind;
        logic [3:0]          shape;
        logic [4*ChBits-1:0] color;
        logic [FracBits-1:0] fraction;
        logic                draw;
        logic [31:0]         texture;
        logic                texture_present;
    } res_t;

    function automatic logic kind_draws(input logic [3:0] k);
        return (k != K_PASS) && (k != K_WIDE) && (k <= K_NOCOL);
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/scf_front.sv =====
// scf_front: input stage; holds each command in a two-entry queue toward the
// back end. Depends on scf_pkg.
`default_nettype none
module scf_front
    import scf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire cmd_t       in_cmd,
    output logic            q_valid,
    input  wire logic       q_ready,
    output cmd_t            q_cmd
);
    cmd_t       mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = cnt_reg != 2'd2;
    assign q_valid  = cnt_reg != 2'd0;
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;
    assign q_cmd    = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wr_reg <= ~wr_reg;
            if (pop)  rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/scf_divider.sv =====
// scf_divider: restoring serial divider, one quotient bit per cycle.
// Depends on scf_pkg.
`default_nettype none
module scf_divider
    import scf_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [DivBits-1:0]  dividend,
    input  wire logic [TimeBits-1:0] divisor,
    output logic                     done,
    output logic [DivBits-1:0]       quotient
);
    localparam int CntBits = $clog2(DivBits + 1);
    logic [DivBits-1:0]  q_reg;
    logic [TimeBits:0]   r_reg;
    logic [TimeBits-1:0] d_reg;
    logic [CntBits-1:0]  cnt_reg;
    logic                busy_reg;
    logic [TimeBits:0]   shifted;
    logic                ge;

    assign shifted  = {r_reg[TimeBits-1:0], q_reg[DivBits-1]};
    assign ge       = shifted >= {1'b0, d_reg};
    assign quotient = q_reg;
    assign done     = busy_reg && cnt_reg == CntBits'(0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CntBits'(DivBits);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CntBits'(0)) busy_reg <= 1'b0;
            else                        cnt_reg <= cnt_reg - CntBits'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg && cnt_reg != CntBits'(0))
        begin
            r_reg <= ge ? shifted - {1'b0, d_reg} : shifted;
            q_reg <= {q_reg[DivBits-2:0], ge};
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/scf_back.sv =====
// scf_back: state update sequencer; one divide per channel on a fade tick, one for the
// fraction if fade time is set, through a shared serial divider. Depends on scf_pkg, scf_divider.
`default_nettype none
module scf_back
    import scf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_valid,
    output logic      q_ready,
    input  wire cmd_t q_cmd,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      out_res
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_WAIT = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t              state_reg;
    logic [3:0]          cur_reg, pend_reg, shape_reg;
    logic [ChBits-1:0]   prev_reg [4];
    logic [ChBits-1:0]   targ_reg [4];
    logic [ChBits-1:0]   pres_reg [4];
    logic [TimeBits-1:0] left_reg, total_reg;
    logic [31:0]         tex_reg;
    logic                texf_reg;
    logic [2:0]          idx_reg;
    logic [DivBits-1:0]  num_reg;
    logic                dv_start;
    logic                dv_done;
    logic [DivBits-1:0]  dv_q;
    logic [FracBits-1:0] frac_reg;

    scf_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start),
        .dividend (num_reg),
        .divisor  (total_reg),
        .done     (dv_done),
        .quotient (dv_q)
    );

    assign q_ready   = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT && !out_ready ? 1'b1 : state_reg == S_OUT;
    assign dv_start  = state_reg == S_DIV;

    logic [TimeBits-1:0] done_t;
    assign done_t = total_reg - left_reg;

    always_comb
    begin
        out_res.kind            = cur_reg;
        out_res.shape           = shape_reg;
        out_res.color           = {pres_reg[3], pres_reg[2], pres_reg[1], pres_reg[0]};
        out_res.fraction        = frac_reg;
        out_res.draw            = kind_draws(cur_reg);
        out_res.texture         = tex_reg;
        out_res.texture_present = texf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cur_reg   <= K_PASS;
            pend_reg  <= K_PASS;
            shape_reg <= '0;
            left_reg  <= '0;
            total_reg <= '0;
            tex_reg   <= '0;
            texf_reg  <= 1'b0;
            idx_reg   <= '0;
            num_reg   <= '0;
            frac_reg  <= '0;
            for (int i = 0; i < 4; i++)
            begin
                prev_reg[i] <= '0;
                targ_reg[i] <= '0;
                pres_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        logic [3:0]          k;
                        logic [3:0]          sh;
                        logic [4*ChBits-1:0] col;
                        logic                tg;
                        logic [3:0]          from;
                        logic [4*ChBits-1:0] tcol;
                        logic [4*ChBits-1:0] pcol;
                        logic [4*ChBits-1:0] vcol;
                        logic [2:0]          nidx;
                        logic [TimeBits-1:0] nl;
                        k    = q_cmd.kind;
                        sh   = q_cmd.shape;
                        col  = q_cmd.color;
                        tg   = q_cmd.texture_given;
                        from = pend_reg;
                        nidx = 3'd4;
                        nl   = '0;
                        for (int i = 0; i < 4; i++)
                        begin
                            tcol[i*ChBits +: ChBits] = targ_reg[i];
                            pcol[i*ChBits +: ChBits] = prev_reg[i];
                            vcol[i*ChBits +: ChBits] = pres_reg[i];
                        end
                        if (q_cmd.op == OP_DISABLE)
                        begin
                            k   = K_PASS;
                            sh  = shape_reg;
                            col = '1;
                            tg  = 1'b0;
                        end
                        unique case (q_cmd.op)
                            OP_TICK:
                            begin
                                if (left_reg != '0)
                                begin
                                    nl = (q_cmd.elapsed >= left_reg) ? '0
                                        : left_reg - q_cmd.elapsed;
                                    left_reg <= nl;
                                    nidx     = 3'd0;
                                    if (nl == '0)
                                    begin
                                        cur_reg <= pend_reg;
                                        if (pend_reg == K_PASS)
                                        begin
                                            tex_reg  <= '0;
                                            texf_reg <= 1'b0;
                                        end
                                    end
                                end
                            end
                            OP_SET, OP_DISABLE:
                            begin
                                if (tg)
                                begin
                                    tex_reg  <= q_cmd.texture_id;
                                    texf_reg <= 1'b1;
                                end
                                shape_reg <= sh;
                                if (q_cmd.fade_time == '0)
                                begin
                                    total_reg <= '0;
                                    left_reg  <= '0;
                                    pend_reg  <= k;
                                    cur_reg   <= k;
                                    tcol = col;
                                    pcol = col;
                                    vcol = col;
                                end
                                else
                                begin
                                    left_reg  <= q_cmd.fade_time;
                                    total_reg <= q_cmd.fade_time;
                                    pend_reg  <= k;
                                    tcol = col;
                                    pcol = vcol;
                                    if (k == K_PASS)
                                    begin
                                        cur_reg <= from;
                                        if (from == K_MUL)
                                            tcol = '1;
                                        else if (from == K_ADD || from == K_BLEND)
                                            tcol[3*ChBits +: ChBits] = '0;
                                    end
                                    else
                                    begin
                                        cur_reg <= k;
                                        if (from == K_PASS && k == K_MUL)
                                        begin
                                            vcol = '1;
                                        end
                                        else if (from == K_PASS &&
                                                 (k == K_ADD || k == K_BLEND))
                                        begin
                                            vcol = col;
                                            vcol[3*ChBits +: ChBits] = '0;
                                            pcol = vcol;
                                        end
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                        for (int i = 0; i < 4; i++)
                        begin
                            targ_reg[i] <= tcol[i*ChBits +: ChBits];
                            prev_reg[i] <= pcol[i*ChBits +: ChBits];
                            pres_reg[i] <= vcol[i*ChBits +: ChBits];
                        end
                        idx_reg   <= nidx;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    if (idx_reg == 3'd4)
                    begin
                        num_reg <= DivBits'({done_t, 16'h0000})
                                 + DivBits'(total_reg >> 1);
                        if (total_reg == '0)
                        begin
                            frac_reg  <= (pend_reg == K_PASS) ? '0 : FracBits'(65536);
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_DIV;
                        end
                    end
                    else
                    begin
                        num_reg <= DivBits'(targ_reg[idx_reg[1:0]]) * DivBits'(done_t)
                                 + DivBits'(prev_reg[idx_reg[1:0]]) * DivBits'(left_reg)
                                 + DivBits'(total_reg >> 1);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (dv_done)
                    begin
                        if (idx_reg == 3'd4)
                        begin
                            frac_reg  <= (pend_reg == K_PASS)
                                ? FracBits'(65536) - dv_q[FracBits-1:0]
                                : dv_q[FracBits-1:0];
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            pres_reg[idx_reg[1:0]] <= (dv_q > DivBits'({ChBits{1'b1}}))
                                ? '1 : dv_q[ChBits-1:0];
                            idx_reg   <= idx_reg + 3'd1;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/screen_filter_color_fader.sv =====
// screen_filter_color_fader: top level; input queue, sequencer and output port.
// Depends on scf_pkg, scf_front, scf_back.
//
//  channel   dir  contents
//  s_axis    in   command word (tdata), op (tuser)
//  m_axis    out  result word (tdata)
//
// A tick during a fade runs four channel divides and one fraction divide through
// the shared 33-step serial divider. Any other item runs only the fraction divide,
// or no divide when the fade time in force is zero. Reset clears all filter state
// at once. The input queue holds two words, so the front keeps accepting until
// both entries are full while a result waits on m_axis.
`default_nettype none
module screen_filter_color_fader
    import scf_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // elapsed[15:0], filter_kind[19:16], filter_shape[23:20], fade_time[39:24],
    // red_in, green_in, blue_in, alpha_in [71:40], texture_id[103:72],
    // texture_given[104], zero fill to 112
    input  wire logic [111:0] s_axis_tdata,
    // op[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // active_kind[3:0], active_shape[7:4], red_out, green_out, blue_out,
    // alpha_out [39:8], fade_fraction[56:40], draw_enable[57], texture_out[89:58],
    // texture_present[90], zero fill to 96
    output logic [95:0]       m_axis_tdata
);
    cmd_t in_cmd, q_cmd;
    res_t res;
    logic q_valid, q_ready;

    always_comb
    begin
        in_cmd.op            = op_t'(s_axis_tuser);
        in_cmd.elapsed       = s_axis_tdata[15:0];
        in_cmd.kind          = s_axis_tdata[19:16];
        in_cmd.shape         = s_axis_tdata[23:20];
        in_cmd.fade_time     = s_axis_tdata[39:24];
        in_cmd.color         = s_axis_tdata[71:40];
        in_cmd.texture_id    = s_axis_tdata[103:72];
        in_cmd.texture_given = s_axis_tdata[104];
    end

    scf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (in_cmd),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    scf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_cmd),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {5'd0, res.texture_present, res.texture, res.draw,
                           res.fraction, res.color, res.shape, res.kind};

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[56:40] <= 17'd65536)
        else $error("fraction out of range");
    a_draw: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[57] == kind_draws(m_axis_tdata[3:0]))
        else $error("draw_enable mismatch");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// tb: self-checking bench for screen_filter_color_fader; drives command words,
// predicts every result word and compares it field by field.
// Depends on scf_pkg and screen_filter_color_fader.
`default_nettype none
module tb;
    import scf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        op_t         op;
        logic [15:0] elapsed;
        logic [3:0]  kind;
        logic [3:0]  shape;
        logic [15:0] fade_time;
        logic [7:0]  col [4];
        logic [31:0] tex;
        logic        tex_given;
    } tb_cmd_t;

    typedef struct packed {
        logic        tex_present;
        logic [31:0] tex;
        logic        draw;
        logic [16:0] frac;
        logic [31:0] color;
        logic [3:0]  shape;
        logic [3:0]  kind;
    } fade_res_t;

    typedef struct {
        tb_cmd_t   c;
        logic      has_exp;
        fade_res_t exp_res;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;

    screen_filter_color_fader i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // predictor state
    logic [3:0]  cur_kind, pend_kind, shape_q;
    logic [7:0]  prev_c [4];
    logic [7:0]  tgt_c [4];
    logic [7:0]  pres_c [4];
    logic [15:0] t_left, t_total;
    logic [31:0] tex_q;
    logic        tex_flag;

    fade_res_t expected_words[$];
    int        errors;
    longint    cycle_cnt;
    bit        no_idle;
    bit        hold_rx;
    bit        src_done;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    function automatic void reset_fader();
        cur_kind = K_PASS;
        pend_kind = K_PASS;
        shape_q = '0;
        for (int i = 0; i < 4; i++)
        begin
            prev_c[i] = '0;
            tgt_c[i] = '0;
            pres_c[i] = '0;
        end
        t_left = '0;
        t_total = '0;
        tex_q = '0;
        tex_flag = 1'b0;
    endfunction

    function automatic void apply_set(input logic [3:0] kind, input logic [3:0] shape,
                                      input logic [15:0] ft, input logic [7:0] col [4],
                                      input logic given, input logic [31:0] tex);
        if (given)
        begin
            tex_q = tex;
            tex_flag = 1'b1;
        end
        shape_q = shape;
        if (ft == 0)
        begin
            t_total = 0;
            t_left = 0;
            pend_kind = kind;
            cur_kind = kind;
            for (int i = 0; i < 4; i++)
            begin
                tgt_c[i] = col[i];
                pres_c[i] = col[i];
                prev_c[i] = col[i];
            end
            return;
        end
        for (int i = 0; i < 4; i++)
        begin
            tgt_c[i] = col[i];
            prev_c[i] = pres_c[i];
        end
        t_left = ft;
        t_total = ft;
        cur_kind = pend_kind;
        pend_kind = kind;
        if (kind == K_PASS)
        begin
            if (cur_kind == K_MUL)
                for (int i = 0; i < 4; i++) tgt_c[i] = 8'hFF;
            else if (cur_kind == K_ADD || cur_kind == K_BLEND)
                tgt_c[3] = 0;
        end
        else
        begin
            if (cur_kind == K_PASS)
            begin
                if (kind == K_MUL)
                    for (int i = 0; i < 4; i++) pres_c[i] = 8'hFF;
                else if (kind == K_ADD || kind == K_BLEND)
                begin
                    for (int i = 0; i < 4; i++) pres_c[i] = tgt_c[i];
                    pres_c[3] = 0;
                    for (int i = 0; i < 4; i++) prev_c[i] = pres_c[i];
                end
            end
            cur_kind = kind;
        end
    endfunction

    function automatic fade_res_t step_fader(input tb_cmd_t c);
        fade_res_t r;
        logic [7:0] white [4];
        longint unsigned s, tt;
        for (int i = 0; i < 4; i++) white[i] = 8'hFF;
        case (c.op)
            OP_TICK:
                if (t_left != 0)
                begin
                    t_left = (c.elapsed >= t_left) ? 16'd0 : t_left - c.elapsed;
                    for (int i = 0; i < 4; i++)
                    begin
                        s = longint'(tgt_c[i]) * (t_total - t_left)
                          + longint'(prev_c[i]) * t_left + t_total / 2;
                        s = s / t_total;
                        pres_c[i] = (s > 255) ? 8'hFF : s[7:0];
                    end
                    if (t_left == 0)
                    begin
                        cur_kind = pend_kind;
                        if (cur_kind == K_PASS)
                        begin
                            tex_q = '0;
                            tex_flag = 1'b0;
                        end
                    end
                end
            OP_SET:     apply_set(c.kind, c.shape, c.fade_time, c.col, c.tex_given, c.tex);
            OP_DISABLE: apply_set(K_PASS, shape_q, c.fade_time, white, 1'b0, 32'd0);
            default: ;
        endcase
        if (t_total == 0)
            tt = 65536;
        else
            tt = (longint'(t_total - t_left) * 65536 + t_total / 2) / t_total;
        if (pend_kind == K_PASS)
            tt = 65536 - tt;
        r.kind = cur_kind;
        r.shape = shape_q;
        r.color = {pres_c[3], pres_c[2], pres_c[1], pres_c[0]};
        r.frac = tt[16:0];
        r.draw = (cur_kind != K_PASS) && (cur_kind != K_WIDE) && (cur_kind <= K_NOCOL);
        r.tex = tex_q;
        r.tex_present = tex_flag;
        return r;
    endfunction

    function automatic tb_cmd_t rand_cmd();
        tb_cmd_t c;
        int p;
        p = $urandom_range(0, 99);
        c.op = (p < 55) ? OP_TICK : (p < 85) ? OP_SET : (p < 97) ? OP_DISABLE : OP_NONE;
        c.elapsed = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        c.kind = ($urandom_range(0, 19) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8));
        c.shape = 4'($urandom);
        p = $urandom_range(0, 9);
        c.fade_time = (p < 2) ? 16'd0 : (p < 9) ? 16'($urandom_range(1, 200)) : 16'($urandom);
        for (int i = 0; i < 4; i++) c.col[i] = 8'($urandom);
        c.tex = $urandom;
        c.tex_given = 1'($urandom);
        return c;
    endfunction

    function automatic row_t mk(input op_t op, input logic [15:0] el, input logic [3:0] k,
                                input logic [3:0] sh, input logic [15:0] ft,
                                input logic [31:0] rgba, input logic [31:0] tex,
                                input logic tg);
        row_t r;
        r.c.op = op;
        r.c.elapsed = el;
        r.c.kind = k;
        r.c.shape = sh;
        r.c.fade_time = ft;
        for (int i = 0; i < 4; i++) r.c.col[i] = rgba[8*i +: 8];
        r.c.tex = tex;
        r.c.tex_given = tg;
        r.has_exp = 1'b0;
        return r;
    endfunction

    task automatic send_word(input tb_cmd_t c);
        fade_res_t r;
        while (!no_idle && $urandom_range(0, 99) < 9)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= c.op;
        s_axis_tdata <= {7'd0, c.tex_given, c.tex, c.col[3], c.col[2], c.col[1], c.col[0],
                         c.fade_time, c.shape, c.kind, c.elapsed};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        r = step_fader(c);
        expected_words.push_back(r);
    endtask

    row_t table_rows[$];

    initial
    begin
        row_t rw;
        fade_res_t want;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_TICK;
        errors = 0;
        no_idle = 1'b0;
        hold_rx = 1'b0;
        src_done = 1'b0;
        reset_fader();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rw = mk(OP_TICK, 16'hFFFF, 0, 0, 0, 0, 0, 0);
        rw.has_exp = 1'b1;
        rw.exp_res = '{kind: K_PASS, shape: 0, color: 0, frac: 17'd0, draw: 0, tex: 0,
                       tex_present: 0};
        table_rows.push_back(rw);
        rw = mk(OP_SET, 0, K_NOCOL, 4'hF, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1);
        rw.has_exp = 1'b1;
        rw.exp_res = '{kind: K_NOCOL, shape: 4'hF, color: 32'hFFFFFFFF, frac: 17'd65536,
                       draw: 1, tex: 32'hFFFFFFFF, tex_present: 1};
        table_rows.push_back(rw);
        table_rows.push_back(mk(OP_SET, 0, K_PASS, 0, 0, 0, 0, 0));
        table_rows.push_back(mk(OP_SET, 0, K_PASS, 3, 100, 32'h80402010, 0, 0));
        table_rows.push_back(mk(OP_SET, 0, K_MUL, 3, 100, 32'h11223344, 32'h55AA, 1));
        table_rows.push_back(mk(OP_TICK, 50, 0, 0, 0, 0, 0, 0));
        table_rows.push_back(mk(OP_SET, 0, K_PASS, 2, 60, 32'h01020304, 0, 0));
        table_rows.push_back(mk(OP_TICK, 30, 0, 0, 0, 0, 0, 0));
        table_rows.push_back(mk(OP_TICK, 16'hFFFF, 0, 0, 0, 0, 0, 0));
        table_rows.push_back(mk(OP_SET, 0, K_ADD, 1, 16'hFFFF, 32'hAABBCCDD, 7, 1));
        table_rows.push_back(mk(OP_TICK, 1, 0, 0, 0, 0, 0, 0));
        table_rows.push_back(mk(OP_SET, 0, K_PASS, 1, 10, 32'hFFFFFFFF, 0, 0));
        table_rows.push_back(mk(OP_TICK, 10, 0, 0, 0, 0, 0, 0));
        table_rows.push_back(mk(OP_SET, 0, K_BLEND, 5, 20, 32'h0000FF00, 9, 1));
        table_rows.push_back(mk(OP_DISABLE, 0, 0, 0, 20, 0, 0, 0));
        table_rows.push_back(mk(OP_TICK, 19, 0, 0, 0, 0, 0, 0));
        table_rows.push_back(mk(OP_TICK, 1, 0, 0, 0, 0, 0, 0));
        table_rows.push_back(mk(OP_SET, 0, 4'd2, 6, 0, 32'h12345678, 3, 1));
        table_rows.push_back(mk(OP_SET, 0, 4'd4, 7, 5, 0, 0, 0));
        table_rows.push_back(mk(OP_SET, 0, K_WIDE, 8, 5, 0, 0, 0));
        table_rows.push_back(mk(OP_SET, 0, 4'd7, 9, 5, 0, 0, 0));
        table_rows.push_back(mk(OP_SET, 0, 4'd15, 10, 0, 0, 0, 0));
        table_rows.push_back(mk(OP_DISABLE, 0, 0, 0, 0, 0, 0, 0));
        table_rows.push_back(mk(OP_NONE, 16'hFFFF, 4'hF, 4'hF, 16'hFFFF, 32'hFFFFFFFF,
                                32'hFFFFFFFF, 1));

        foreach (table_rows[i])
        begin
            want = step_fader(table_rows[i].c);
            if (table_rows[i].has_exp && want != table_rows[i].exp_res)
                report_mismatch("table row", i, 0);
        end
        reset_fader();
        foreach (table_rows[i])
            send_word(table_rows[i].c);

        for (int n = 0; n < 1700; n++)
        begin
            no_idle = (n >= 600 && n < 900);
            if (n == 1000)
                hold_rx = 1'b1;
            send_word(rand_cmd());
        end
        s_axis_tvalid <= 1'b0;
        src_done = 1'b1;
    end

    // receiver: random stalls and one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_rx)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 9);
    end

    initial
    begin
        @(posedge hold_rx);
        force_hold();
    end

    task automatic force_hold();
        int n;
        n = 0;
        while (n < 3000)
        begin
            @(posedge clk);
            n++;
        end
        hold_rx = 1'b0;
    endtask

    // check result words
    always @(posedge clk)
    begin
        fade_res_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[90:0];
            if (expected_words.size() == 0)
                report_mismatch("unexpected word", got.kind, 0);
            else
            begin
                want = expected_words.pop_front();
                if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
                if (got.shape != want.shape) report_mismatch("shape", got.shape, want.shape);
                if (got.color != want.color) report_mismatch("color", got.color, want.color);
                if (got.frac != want.frac) report_mismatch("fraction", got.frac, want.frac);
                if (got.draw != want.draw) report_mismatch("draw", got.draw, want.draw);
                if (got.tex != want.tex) report_mismatch("texture", got.tex, want.tex);
                if (got.tex_present != want.tex_present)
                    report_mismatch("texture_present", got.tex_present, want.tex_present);
            end
        end
    end

    initial
    begin
        cycle_cnt = 0;
        while (!(src_done && expected_words.size() == 0) && cycle_cnt < 2000000)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        if (cycle_cnt >= 2000000)
        begin
            $display("[screen_filter_color_fader] ERROR");
            $finish;
        end
        else
        begin
            repeat (400) @(posedge clk);
            if (errors == 0)
                $display("[screen_filter_color_fader] OK");
            else
                $display("[screen_filter_color_fader] ERROR");
            $finish;
        end
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/scf_pkg.sv
hw/rtl/scf_front.sv
hw/rtl/scf_divider.sv
hw/rtl/scf_back.sv
hw/rtl/screen_filter_color_fader.sv
sim/tb.sv
